@@ rtl/pslv_pkg.sv @@
// pslv_pkg: shared constants and types for the plucked-string loop voice.
// Used by pslv_mac, pslv_div and plucked_string_loop_voice_core.
package pslv_pkg;

    // Delay line
    localparam int DELAY_DEPTH = 16384;
    localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
    localparam int PER_W       = DELAY_AW + 8;   // period / position in Q.8

    // Allpass chain
    localparam int ALLPASS_STAGES = 4;
    localparam int AP_IW = (ALLPASS_STAGES > 1) ? $clog2(ALLPASS_STAGES) : 1;

    // Tanh shaper table, Q0.30 values, TANH_ENTRIES+1 entries
    localparam int TANH_ENTRIES = 1024;
    localparam int TANH_BITS    = $clog2(TANH_ENTRIES);
    localparam int TANH_AW      = TANH_BITS + 1;
    localparam int TANH_VW      = 30;
    localparam longint TANH_H   = (longint'(1) << 32) / TANH_ENTRIES;
    localparam longint TANH_H3  = (((TANH_H * TANH_H) >> 30) * TANH_H) >> 30;
    localparam longint TANH_TH  = TANH_H - TANH_H3 / 3;

    // Shared multiplier / accumulator
    localparam int MUL_AW = 32;
    localparam int MUL_BW = 26;
    localparam int PROD_W = MUL_AW + MUL_BW;
    localparam int ACC_W  = PROD_W + 2;

    // Divider (table build)
    localparam int DIV_W  = 31;
    localparam int QUOT_W = TANH_VW;

    // Fixed-point limits
    localparam int CLIP_12  = 1258291;
    localparam int ONE_Q20  = 1048576;
    localparam int MAX24    = 8388607;
    localparam int MIN24    = -8388608;
    localparam int UNITY16  = 65536;
    localparam int MIN_PER  = 512;
    localparam int G_MAX    = 4194303;
    localparam int OUT_MAX  = 32767;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DELAY_PERIOD   = 3'd0,
        CFG_FOLD_THRESHOLD = 3'd1,
        CFG_FOLD_GAIN      = 3'd2,
        CFG_DAMPING        = 3'd3,
        CFG_LOOP_GAIN      = 3'd4,
        CFG_DISPERSION     = 3'd5,
        CFG_DC_POLE        = 3'd6,
        CFG_OUTPUT_GAIN    = 3'd7
    } t_cfg_idx;

    localparam int CFG_DW = 22;

    // Multiplier request: operands and accumulate flag
    typedef struct packed {
        logic                     acc;
        logic signed [MUL_AW-1:0] a;
        logic signed [MUL_BW-1:0] b;
    } t_mac_req;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/plucked_string_loop_voice_core.sv @@
// plucked_string_loop_voice_core: top level of the plucked-string voice.
// Depends on pslv_pkg, pslv_mac (shared multiplier) and pslv_div (divider).
//
// Usage:
//  - Input stream (s_axis): tuser = op (0 render tick, 1 load excitation);
//    tdata = excite_offset [4:0], excite_value [22:5]. A transaction completes
//    when tvalid and tready are both high.
//  - Output stream (m_axis): one 16-bit Q1.15 sample per render tick; loads
//    produce nothing.
//  - Config port: write enable, 3-bit register index, 22-bit data; the user
//    must write it only while the voice is idle; the block does not enforce this.
//  - Timing: a load is written to the line as it is accepted and leaves the
//    voice idle. A render tick steps through its states in turn, each filter
//    step going through the single shared multiplier, and the voice takes no
//    new item until the tick is done; tready is low while a tick is in progress.
//  - Reset: the tanh table is built in place by the multiplier and the
//    serial divider, one entry per division, while a clearing pass writes
//    zero to every delay-line entry; tready stays low until both end.
//  - Stall: a finished sample waits in the output register; the next tick may
//    be accepted, and it holds at its final step until the register frees.
module plucked_string_loop_voice_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [23:0]                 i_s_axis_tdata,  // [4:0] excite_offset, [22:5] excite_value
    input  logic                        i_s_axis_tuser,  // [0] op
    // output stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [15:0]                 o_m_axis_tdata,  // [15:0] sample_out
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic [2:0]                  i_cfg_index,
    input  logic [pslv_pkg::CFG_DW-1:0] i_cfg_wdata
);
    localparam int ACC_W = pslv_pkg::ACC_W;
    localparam int DAW   = pslv_pkg::DELAY_AW;
    localparam int PER_W = pslv_pkg::PER_W;
    localparam int TAW   = pslv_pkg::TANH_AW;
    localparam int TVW   = pslv_pkg::TANH_VW;
    localparam int TB    = pslv_pkg::TANH_BITS;
    localparam int FRB   = 22 - TB;   // fraction bits of |g| below the table index

    typedef enum logic [5:0] {
        S_INIT_Z, S_INIT_MUL, S_INIT_MW, S_INIT_DIV, S_INIT_DWT, S_INIT_CLR,
        S_IDLE,
        S_RD1, S_RD2, S_RD3, S_RW1, S_SIG, S_FMUL, S_FW, S_FOLD,
        S_LP1, S_LP2, S_LPW, S_LP, S_G, S_GW, S_X,
        S_AP, S_APW, S_APY, S_DC, S_DCW, S_DCY,
        S_WR, S_OW, S_SHP, S_T1, S_T2, S_T3, S_T4, S_TW, S_TV
    } t_state;

    // ---------------- configuration registers ----------------
    logic [21:0]        r_period;
    logic [17:0]        r_fthr;
    logic [17:0]        r_fgain;
    logic [16:0]        r_damp;
    logic [16:0]        r_lgain;
    logic signed [17:0] r_disp;
    logic [16:0]        r_pole;
    logic [17:0]        r_ogain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 22'(pslv_pkg::MIN_PER);
            r_fthr   <= 18'(pslv_pkg::UNITY16);
            r_fgain  <= '0;
            r_damp   <= 17'(pslv_pkg::UNITY16);
            r_lgain  <= '0;
            r_disp   <= '0;
            r_pole   <= 17'd64880;
            r_ogain  <= 18'(pslv_pkg::UNITY16);
        end else if (i_cfg_wr_en) begin
            case (pslv_pkg::t_cfg_idx'(i_cfg_index))
                pslv_pkg::CFG_DELAY_PERIOD:   r_period <= i_cfg_wdata;
                pslv_pkg::CFG_FOLD_THRESHOLD: r_fthr   <= i_cfg_wdata[17:0];
                pslv_pkg::CFG_FOLD_GAIN:      r_fgain  <= i_cfg_wdata[17:0];
                pslv_pkg::CFG_DAMPING:        r_damp   <= i_cfg_wdata[16:0];
                pslv_pkg::CFG_LOOP_GAIN:      r_lgain  <= i_cfg_wdata[16:0];
                pslv_pkg::CFG_DISPERSION:     r_disp   <= $signed(i_cfg_wdata[17:0]);
                pslv_pkg::CFG_DC_POLE:        r_pole   <= i_cfg_wdata[16:0];
                pslv_pkg::CFG_OUTPUT_GAIN:    r_ogain  <= i_cfg_wdata[17:0];
                default: ;
            endcase
        end
    end

    // saturated coefficients
    logic [16:0]        w_damp, w_damp_c, w_lg, w_pole;
    logic signed [17:0] w_disp;
    assign w_damp   = (r_damp  > 17'(pslv_pkg::UNITY16)) ? 17'(pslv_pkg::UNITY16) : r_damp;
    assign w_damp_c = 17'(pslv_pkg::UNITY16) - w_damp;
    assign w_lg     = (r_lgain > 17'(pslv_pkg::UNITY16)) ? 17'(pslv_pkg::UNITY16) : r_lgain;
    assign w_pole   = (r_pole  > 17'(pslv_pkg::UNITY16)) ? 17'(pslv_pkg::UNITY16) : r_pole;
    assign w_disp   = (r_disp > 18'sd65536)  ? 18'sd65536 :
                      (r_disp < -18'sd65536) ? -18'sd65536 : r_disp;

    // ---------------- state ----------------
    t_state             r_state;
    logic [DAW-1:0]     r_wi;
    logic [DAW-1:0]     r_i2;
    logic [7:0]         r_fr;
    logic signed [21:0] r_sig;
    logic               r_fold;
    logic signed [23:0] r_lp;
    logic signed [23:0] r_x;
    logic signed [23:0] r_ap_in  [pslv_pkg::ALLPASS_STAGES];
    logic signed [23:0] r_ap_out [pslv_pkg::ALLPASS_STAGES];
    logic [pslv_pkg::AP_IW-1:0] r_j;
    logic signed [23:0] r_dc_in;
    logic signed [23:0] r_dc_out;
    logic signed [21:0] r_s;
    logic [TB-1:0]      r_tk_idx;
    logic [21:0]        r_tf;
    logic               r_neg;
    logic [TVW-1:0]     r_tk;
    logic signed [TVW:0] r_diff;
    logic               r_ovalid;
    logic [15:0]        r_out;
    // table build
    logic [TB-1:0]      r_k;
    logic [TVW-1:0]     r_t;
    // delay-line clearing pass
    logic [DAW-1:0]     r_clr;
    logic               r_clr_done;

    // ---------------- memories ----------------
    logic signed [17:0] r_line [pslv_pkg::DELAY_DEPTH];
    logic signed [17:0] r_line_q;
    logic [TVW-1:0]     r_tanh [pslv_pkg::TANH_ENTRIES + 1];
    logic [TVW-1:0]     r_tanh_q;

    logic               w_ln_we;
    logic [DAW-1:0]     w_ln_wa, w_ln_ra;
    logic signed [17:0] w_ln_wd;
    logic               w_th_we;
    logic [TAW-1:0]     w_th_wa, w_th_ra;
    logic [TVW-1:0]     w_th_wd;

    always_ff @(posedge i_clk) begin
        if (w_ln_we) begin
            r_line[w_ln_wa] <= w_ln_wd;
        end
        r_line_q <= r_line[w_ln_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_th_we) begin
            r_tanh[w_th_wa] <= w_th_wd;
        end
        r_tanh_q <= r_tanh[w_th_ra];
    end

    // ---------------- shared units ----------------
    pslv_pkg::t_mac_req  w_req;
    logic signed [ACC_W-1:0] w_acc;
    pslv_pkg::t_div_stat w_dstat;
    logic                w_dstart;
    logic [pslv_pkg::DIV_W-1:0]  w_dnum, w_dden;
    logic [pslv_pkg::QUOT_W-1:0] w_quot;

    pslv_mac u_mac (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_acc (w_acc)
    );

    pslv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_stat  (w_dstat),
        .o_quot  (w_quot)
    );

    // round half up by s bits
    function automatic logic signed [ACC_W-1:0] f_rnd(input logic signed [ACC_W-1:0] v,
                                                     input logic [4:0] s);
        logic signed [ACC_W-1:0] half;
        half = ACC_W'(1) <<< (s - 5'd1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [ACC_W-1:0] f_clip(input logic signed [ACC_W-1:0] v,
                                                      input logic signed [ACC_W-1:0] lo,
                                                      input logic signed [ACC_W-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    localparam logic signed [ACC_W-1:0] L_CLIP12 = ACC_W'(pslv_pkg::CLIP_12);
    localparam logic signed [ACC_W-1:0] L_ONE20  = ACC_W'(pslv_pkg::ONE_Q20);
    localparam logic signed [ACC_W-1:0] L_MAX24  = ACC_W'(pslv_pkg::MAX24);
    localparam logic signed [ACC_W-1:0] L_MIN24  = ACC_W'(pslv_pkg::MIN24);

    // read position: write pointer minus the period, in Q.8, wrapping in the line
    logic [21:0]      w_per22;
    logic [PER_W-1:0] w_per, w_pos;
    assign w_per22 = (r_period < 22'(pslv_pkg::MIN_PER)) ? 22'(pslv_pkg::MIN_PER) : r_period;
    assign w_per   = PER_W'(w_per22);
    assign w_pos   = {r_wi, 8'd0} - w_per;

    // input fields
    logic               w_in_op;
    logic [4:0]         w_in_off;
    logic signed [17:0] w_in_val;
    logic               w_in_acc;
    assign w_in_op  = i_s_axis_tuser;
    assign w_in_off = i_s_axis_tdata[4:0];
    assign w_in_val = $signed(i_s_axis_tdata[22:5]);
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // datapath values taken from the accumulator
    logic signed [ACC_W-1:0] w_t60, w_sig60, w_fold60, w_pick, w_r16, w_ap_y, w_dc;
    logic signed [ACC_W-1:0] w_g, w_gabs, w_v, w_r15;
    logic signed [ACC_W-1:0] w_sigc, w_sc, w_wrd;
    logic [21:0]             w_m;
    logic signed [22:0]      w_fdiff;
    logic signed [24:0]      w_apd;
    logic [15:0]             w_r;

    assign w_t60    = ACC_W'({r_fthr[15:0], 4'd0});
    assign w_sig60  = f_rnd(w_acc, 5'd4);
    assign w_r16    = f_rnd(w_acc, 5'd16);
    assign w_fold60 = w_t60 - w_r16;
    assign w_pick   = r_fold ? w_fold60 : ACC_W'(r_sig);
    assign w_sigc   = f_clip(w_pick, -L_CLIP12, L_CLIP12);
    assign w_fdiff  = 23'(r_sig) - $signed({2'b00, r_fthr[15:0], 4'd0});
    assign w_apd    = 25'(r_x) - 25'(r_ap_out[r_j]);
    assign w_ap_y   = f_clip(w_r16 + ACC_W'(r_ap_in[r_j]), L_MIN24, L_MAX24);
    assign w_dc     = f_clip(ACC_W'(r_x) - ACC_W'(r_dc_in) + w_r16, L_MIN24, L_MAX24);
    assign w_sc     = f_clip(w_dc, -L_ONE20, L_ONE20);
    assign w_wrd    = f_rnd(ACC_W'(r_s), 5'd4);
    assign w_g      = w_r16;
    assign w_gabs   = (w_g < 0) ? -w_g : w_g;
    assign w_m      = (w_gabs > ACC_W'(pslv_pkg::G_MAX)) ? 22'(pslv_pkg::G_MAX) : w_gabs[21:0];
    assign w_v      = ACC_W'({1'b0, r_tk}) + (w_acc >>> 22);
    assign w_r15    = f_rnd(w_v, 5'd15);
    assign w_r      = (w_r15 > ACC_W'(pslv_pkg::OUT_MAX)) ? 16'(pslv_pkg::OUT_MAX) : w_r15[15:0];

    // ---------------- control decode ----------------
    always_comb begin
        w_req    = '0;
        w_ln_we  = 1'b0;
        w_ln_wa  = r_wi;
        w_ln_wd  = '0;
        w_ln_ra  = r_i2;
        w_th_we  = 1'b0;
        w_th_wa  = '0;
        w_th_wd  = '0;
        w_th_ra  = TAW'(r_tk_idx);
        w_dstart = 1'b0;
        w_dnum   = pslv_pkg::DIV_W'(r_t) + pslv_pkg::DIV_W'(pslv_pkg::TANH_TH);
        w_dden   = pslv_pkg::DIV_W'(longint'(1) << 30) + pslv_pkg::DIV_W'(w_acc[ACC_W-1:30]);

        case (r_state)
            S_INIT_Z: begin
                w_th_we = 1'b1;
            end
            S_INIT_MUL: begin
                w_req.a = pslv_pkg::MUL_AW'(r_t);
                w_req.b = pslv_pkg::MUL_BW'(pslv_pkg::TANH_TH);
            end
            S_INIT_DIV: begin
                w_dstart = 1'b1;
            end
            S_INIT_DWT: begin
                w_th_we = w_dstat.done;
                w_th_wa = TAW'(r_k) + 1'b1;
                w_th_wd = w_quot;
            end
            S_IDLE: begin
                w_ln_we = w_in_acc && w_in_op;
                w_ln_wa = r_wi - DAW'(w_in_off);
                w_ln_wd = w_in_val;
            end
            S_RD1: begin
                w_ln_ra = w_pos[PER_W-1:8];
            end
            S_RD2: begin
                w_req.a = pslv_pkg::MUL_AW'(r_line_q);
                w_req.b = pslv_pkg::MUL_BW'(9'd256 - {1'b0, r_fr});
            end
            S_RD3: begin
                w_req.acc = 1'b1;
                w_req.a   = pslv_pkg::MUL_AW'(r_line_q);
                w_req.b   = pslv_pkg::MUL_BW'(r_fr);
            end
            S_FMUL: begin
                w_req.a = pslv_pkg::MUL_AW'(w_fdiff);
                w_req.b = pslv_pkg::MUL_BW'(r_fgain);
            end
            S_LP1: begin
                w_req.a = pslv_pkg::MUL_AW'(r_sig);
                w_req.b = pslv_pkg::MUL_BW'(w_damp);
            end
            S_LP2: begin
                w_req.acc = 1'b1;
                w_req.a   = pslv_pkg::MUL_AW'(r_lp);
                w_req.b   = pslv_pkg::MUL_BW'(w_damp_c);
            end
            S_G: begin
                w_req.a = pslv_pkg::MUL_AW'(r_lp);
                w_req.b = pslv_pkg::MUL_BW'(w_lg);
            end
            S_AP: begin
                w_req.a = pslv_pkg::MUL_AW'(w_disp);
                w_req.b = pslv_pkg::MUL_BW'(w_apd);
            end
            S_DC: begin
                w_req.a = pslv_pkg::MUL_AW'(r_dc_out);
                w_req.b = pslv_pkg::MUL_BW'(w_pole);
            end
            S_WR: begin
                w_ln_we = 1'b1;
                w_ln_wa = r_wi;
                w_ln_wd = w_wrd[17:0];
                w_req.a = pslv_pkg::MUL_AW'(r_s);
                w_req.b = pslv_pkg::MUL_BW'(r_ogain);
            end
            S_T2: begin
                w_th_ra = TAW'(r_tk_idx) + 1'b1;
            end
            S_T4: begin
                w_req.a = pslv_pkg::MUL_AW'(r_diff);
                w_req.b = pslv_pkg::MUL_BW'(r_tf);
            end
            default: ;
        endcase

        // clearing pass owns the write port until it ends
        if (!r_clr_done) begin
            w_ln_we = 1'b1;
            w_ln_wa = r_clr;
            w_ln_wd = '0;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT_Z;
            r_wi       <= '0;
            r_lp       <= '0;
            r_dc_in    <= '0;
            r_dc_out   <= '0;
            r_ovalid   <= 1'b0;
            r_clr      <= '0;
            r_clr_done <= 1'b0;
            r_k        <= '0;
            r_t        <= '0;
            r_j        <= '0;
            for (int i = 0; i < pslv_pkg::ALLPASS_STAGES; i++) begin
                r_ap_in[i]  <= '0;
                r_ap_out[i] <= '0;
            end
        end else begin
            if (!r_clr_done) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == DAW'(pslv_pkg::DELAY_DEPTH - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_INIT_Z: begin
                    r_t     <= '0;
                    r_k     <= '0;
                    r_state <= S_INIT_MUL;
                end
                S_INIT_MUL: r_state <= S_INIT_MW;
                S_INIT_MW:  r_state <= S_INIT_DIV;
                S_INIT_DIV: r_state <= S_INIT_DWT;
                S_INIT_DWT: begin
                    if (w_dstat.done) begin
                        r_t <= w_quot;
                        r_k <= r_k + 1'b1;
                        if (r_k == TB'(pslv_pkg::TANH_ENTRIES - 1)) begin
                            r_state <= S_INIT_CLR;
                        end else begin
                            r_state <= S_INIT_MUL;
                        end
                    end
                end
                S_INIT_CLR: begin
                    if (r_clr_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc && !w_in_op) begin
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_fr    <= w_pos[7:0];
                    r_i2    <= w_pos[PER_W-1:8] + 1'b1;
                    r_state <= S_RD2;
                end
                S_RD2: r_state <= S_RD3;
                S_RD3: r_state <= S_RW1;
                S_RW1: r_state <= S_SIG;
                S_SIG: begin
                    r_sig   <= w_sig60[21:0];
                    r_fold  <= (r_fthr < 18'(pslv_pkg::UNITY16)) && (w_sig60 > w_t60);
                    r_state <= S_FMUL;
                end
                S_FMUL: r_state <= S_FW;
                S_FW:   r_state <= S_FOLD;
                S_FOLD: begin
                    r_sig   <= w_sigc[21:0];
                    r_state <= S_LP1;
                end
                S_LP1: r_state <= S_LP2;
                S_LP2: r_state <= S_LPW;
                S_LPW: r_state <= S_LP;
                S_LP: begin
                    r_lp    <= w_r16[23:0];
                    r_state <= S_G;
                end
                S_G:  r_state <= S_GW;
                S_GW: r_state <= S_X;
                S_X: begin
                    r_x     <= w_r16[23:0];
                    r_j     <= '0;
                    r_state <= S_AP;
                end
                S_AP:  r_state <= S_APW;
                S_APW: r_state <= S_APY;
                S_APY: begin
                    r_ap_in[r_j]  <= r_x;
                    r_ap_out[r_j] <= w_ap_y[23:0];
                    r_x           <= w_ap_y[23:0];
                    r_j           <= r_j + 1'b1;
                    if (r_j == pslv_pkg::AP_IW'(pslv_pkg::ALLPASS_STAGES - 1)) begin
                        r_state <= S_DC;
                    end else begin
                        r_state <= S_AP;
                    end
                end
                S_DC:  r_state <= S_DCW;
                S_DCW: r_state <= S_DCY;
                S_DCY: begin
                    r_dc_in  <= r_x;
                    r_dc_out <= w_dc[23:0];
                    r_s      <= w_sc[21:0];
                    r_state  <= S_WR;
                end
                S_WR: begin
                    r_wi    <= r_wi + 1'b1;
                    r_state <= S_OW;
                end
                S_OW: r_state <= S_SHP;
                S_SHP: begin
                    r_neg    <= (w_g < 0);
                    r_tk_idx <= w_m[21:FRB];
                    r_tf     <= {w_m[FRB-1:0], TB'(0)};
                    r_state  <= S_T1;
                end
                S_T1: r_state <= S_T2;
                S_T2: begin
                    r_tk    <= r_tanh_q;
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_diff  <= $signed({1'b0, r_tanh_q}) - $signed({1'b0, r_tk});
                    r_state <= S_T4;
                end
                S_T4: r_state <= S_TW;
                S_TW: r_state <= S_TV;
                S_TV: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_out    <= r_neg ? (16'd0 - w_r) : w_r;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out;

`ifndef NO_ASSERTIONS
    // no transaction is taken before the delay line is cleared
    a_ready_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> r_clr_done)
        else $error("input ready before delay-line clear finished");

    // divider is only started when free
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dstart |-> !w_dstat.busy)
        else $error("divider started while busy");

    // write pointer moves only on the write-back step of a tick
    a_wi_step: assert property (@(posedge i_clk) disable iff (!i_rst_n || !$past(i_rst_n))
        (r_wi != $past(r_wi)) |-> $past(r_state == S_WR))
        else $error("write pointer moved outside write-back");

    // a new output appears only from the final tick step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n || !$past(i_rst_n))
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_TV))
        else $error("output valid raised outside final step");
`endif

endmodule

@@ rtl/pslv_mac.sv @@
// pslv_mac: shared two-stage signed multiply-accumulate unit.
// Depends on pslv_pkg. The product and the accumulator are each registered.
module pslv_mac (
    input  logic                                 i_clk,
    input  pslv_pkg::t_mac_req                   i_req,
    output logic signed [pslv_pkg::ACC_W-1:0]    o_acc
);
    logic signed [pslv_pkg::PROD_W-1:0] r_prod;
    logic                               r_acc_en;
    logic signed [pslv_pkg::ACC_W-1:0]  r_acc;
    logic signed [pslv_pkg::ACC_W-1:0]  w_base;

    assign w_base = r_acc_en ? r_acc : '0;

    always_ff @(posedge i_clk) begin
        r_prod   <= i_req.a * i_req.b;
        r_acc_en <= i_req.acc;
        r_acc    <= w_base + pslv_pkg::ACC_W'(r_prod);
    end

    assign o_acc = r_acc;

endmodule

@@ rtl/pslv_div.sv @@
// pslv_div: restoring divider, one quotient bit per cycle.
// Depends on pslv_pkg. Divides (num << QUOT_W) by den, requires num < den.
module pslv_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pslv_pkg::DIV_W-1:0]    i_num,
    input  logic [pslv_pkg::DIV_W-1:0]    i_den,
    output pslv_pkg::t_div_stat           o_stat,
    output logic [pslv_pkg::QUOT_W-1:0]   o_quot
);
    localparam int CNT_W = $clog2(pslv_pkg::QUOT_W + 1);

    logic [pslv_pkg::DIV_W:0]    r_rem;
    logic [pslv_pkg::DIV_W-1:0]  r_den;
    logic [pslv_pkg::QUOT_W-1:0] r_q;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [pslv_pkg::DIV_W:0]    w_sh;
    logic                        w_ge;

    assign w_sh = {r_rem[pslv_pkg::DIV_W-1:0], 1'b0};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_q    <= '0;
                r_cnt  <= CNT_W'(pslv_pkg::QUOT_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
                r_q   <= {r_q[pslv_pkg::QUOT_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule

@@ bench/tb_plucked_string_loop_voice_core.sv @@
// Testbench for plucked_string_loop_voice_core: streams render ticks and excitation loads,
// predicts each shaped sample with a bit-true model and compares in order.
// Depends on pslv_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_plucked_string_loop_voice_core;

    localparam int N_RANDOM   = 1250;
    localparam int WDOG_LIMIT = 200000;   // covers the table build after reset
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    typedef struct packed {
        logic               op;
        logic [4:0]         offset;
        logic signed [17:0] value;
    } t_voice_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;
    logic i_s_axis_tuser = 1'b0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;
    logic i_cfg_wr_en = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [pslv_pkg::CFG_DW-1:0] i_cfg_wdata = '0;

    plucked_string_loop_voice_core dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- predictor state ----------------
    logic signed [17:0] line_mem [pslv_pkg::DELAY_DEPTH];
    int unsigned        wr_ptr;
    longint             lp_acc, ap_x [pslv_pkg::ALLPASS_STAGES], ap_y [pslv_pkg::ALLPASS_STAGES];
    longint             dc_x, dc_y;
    longint             tanh_tab [pslv_pkg::TANH_ENTRIES+1];
    longint unsigned    r_period, r_thresh, r_fgain, r_damp, r_lgain, r_pole, r_ogain;
    longint             r_disp;

    t_voice_item     pending_items [$];
    logic [15:0]     expected_samples [$];
    int              error_count = 0;
    logic            random_idle = 1'b1;

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [15:0] tanh_shape(longint g);
        longint m, q, k, f, v, r;
        m = g < 0 ? -g : g;
        if (m > pslv_pkg::G_MAX) m = pslv_pkg::G_MAX;
        q = m * pslv_pkg::TANH_ENTRIES;
        k = q >> 22;
        f = q & pslv_pkg::G_MAX;
        v = tanh_tab[k] + (((tanh_tab[k+1] - tanh_tab[k]) * f) >>> 22);
        r = rnd_shift(v, 15);
        if (r > pslv_pkg::OUT_MAX) r = pslv_pkg::OUT_MAX;
        return 16'(g < 0 ? -r : r);
    endfunction

    task automatic voice_reset_state();
        longint t;
        for (int i = 0; i < pslv_pkg::DELAY_DEPTH; i++) line_mem[i] = '0;
        for (int j = 0; j < pslv_pkg::ALLPASS_STAGES; j++) begin
            ap_x[j] = 0;
            ap_y[j] = 0;
        end
        wr_ptr = 0; lp_acc = 0; dc_x = 0; dc_y = 0;
        r_period = 512; r_thresh = 65536; r_fgain = 0; r_damp = 65536;
        r_lgain = 0; r_disp = 0; r_pole = 64880; r_ogain = 65536;
        tanh_tab[0] = 0;
        for (int k = 0; k < pslv_pkg::TANH_ENTRIES; k++) begin
            t = tanh_tab[k];
            tanh_tab[k+1] = ((t + pslv_pkg::TANH_TH) << 30) /
                            ((longint'(1) << 30) + ((t * pslv_pkg::TANH_TH) >>> 30));
        end
    endtask

    // Returns 1 and the sample for a render tick; loads only touch the line.
    function automatic bit voice_step(t_voice_item it, output logic [15:0] sample);
        longint unsigned span, per, pos, i1, i2, fr;
        longint sig, x, y, th, d, a, p, s;
        span = longint'(pslv_pkg::DELAY_DEPTH) * 256;
        if (it.op == OP_LOAD) begin
            line_mem[(wr_ptr + pslv_pkg::DELAY_DEPTH - it.offset) % pslv_pkg::DELAY_DEPTH] =
                it.value;
            return 0;
        end
        per = r_period < pslv_pkg::MIN_PER ? pslv_pkg::MIN_PER : r_period;
        per = per % span;
        pos = (longint'(wr_ptr) * 256 + span - per) % span;
        i1 = pos >> 8;
        i2 = (i1 + 1) % pslv_pkg::DELAY_DEPTH;
        fr = pos & 255;
        sig = rnd_shift(longint'(line_mem[i1]) * longint'(256 - fr)
                        + longint'(line_mem[i2]) * longint'(fr), 4);
        // bridge fold, only with a threshold below 1.0
        if (r_thresh < pslv_pkg::UNITY16) begin
            th = longint'(r_thresh) << 4;
            if (sig > th) sig = th - rnd_shift((sig - th) * longint'(r_fgain), 16);
        end
        sig = clamp(sig, -pslv_pkg::CLIP_12, pslv_pkg::CLIP_12);
        d = r_damp > pslv_pkg::UNITY16 ? pslv_pkg::UNITY16 : r_damp;
        lp_acc = rnd_shift(sig * d + lp_acc * (pslv_pkg::UNITY16 - d), 16);
        x = rnd_shift(lp_acc * longint'(r_lgain > pslv_pkg::UNITY16 ? pslv_pkg::UNITY16 : r_lgain),
                      16);
        a = clamp(r_disp, -pslv_pkg::UNITY16, pslv_pkg::UNITY16);
        for (int j = 0; j < pslv_pkg::ALLPASS_STAGES; j++) begin
            y = clamp(rnd_shift(a * (x - ap_y[j]), 16) + ap_x[j],
                      pslv_pkg::MIN24, pslv_pkg::MAX24);
            ap_x[j] = x;
            ap_y[j] = y;
            x = y;
        end
        p = r_pole > pslv_pkg::UNITY16 ? pslv_pkg::UNITY16 : r_pole;
        d = clamp(x - dc_x + rnd_shift(p * dc_y, 16), pslv_pkg::MIN24, pslv_pkg::MAX24);
        dc_x = x;
        dc_y = d;
        s = clamp(d, -pslv_pkg::ONE_Q20, pslv_pkg::ONE_Q20);
        line_mem[wr_ptr] = 18'(rnd_shift(s, 4));
        wr_ptr = (wr_ptr + 1) % pslv_pkg::DELAY_DEPTH;
        sample = tanh_shape(rnd_shift(s * longint'(r_ogain), 16));
        return 1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_item(t_voice_item it);
        pending_items = {pending_items, it};
    endtask

    // ---------------- driver ----------------
    t_voice_item cur_item;
    always @(posedge i_clk) begin
        logic [15:0] smp;
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (i_s_axis_tvalid) begin
                    if (voice_step(cur_item, smp))
                        expected_samples = {expected_samples, smp};
                end
                if (pending_items.size() > 0 && !(random_idle && $urandom_range(99) < 31)) begin
                    cur_item = pending_items.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser  <= cur_item.op;
                    i_s_axis_tdata  <= {1'b0, cur_item.value, cur_item.offset};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= !(random_idle && $urandom_range(99) < 31);
        end
    end

    // ---------------- monitor ----------------
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        logic [15:0] exp_s;
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %h", o_m_axis_tdata));
            end else begin
                exp_s = expected_samples.pop_front();
                if (o_m_axis_tdata !== exp_s)
                    report_mismatch($sformatf("sample_out got %h want %h",
                                              o_m_axis_tdata, exp_s));
            end
        end
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic cfg_write(pslv_pkg::t_cfg_idx idx, longint unsigned val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= pslv_pkg::CFG_DW'(val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            pslv_pkg::CFG_DELAY_PERIOD:   r_period = val & 22'h3FFFFF;
            pslv_pkg::CFG_FOLD_THRESHOLD: r_thresh = val & 18'h3FFFF;
            pslv_pkg::CFG_FOLD_GAIN:      r_fgain  = val & 18'h3FFFF;
            pslv_pkg::CFG_DAMPING:        r_damp   = val & 17'h1FFFF;
            pslv_pkg::CFG_LOOP_GAIN:      r_lgain  = val & 17'h1FFFF;
            pslv_pkg::CFG_DISPERSION:     r_disp   = longint'($signed(18'(val)));
            pslv_pkg::CFG_DC_POLE:        r_pole   = val & 17'h1FFFF;
            default:                      r_ogain  = val & 18'h3FFFF;
        endcase
    endtask

    function automatic t_voice_item mk(logic op, logic [4:0] off, logic signed [17:0] v);
        t_voice_item it;
        it.op = op; it.offset = off; it.value = v;
        return it;
    endfunction

    // Wait until the queues drain and the block is done with loads in flight.
    task automatic drain();
        wait (pending_items.size() == 0 && !i_s_axis_tvalid && expected_samples.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    // Random items: about 35 percent loads and the rest ticks, in random order.
    task automatic add_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 35)
                add_item(mk(OP_LOAD, 5'($urandom), 18'($urandom)));
            else
                add_item(mk(OP_TICK, 5'($urandom), 18'($urandom)));
        end
    endtask

    initial begin
        voice_reset_state();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, offset zero, default registers (loop gain zero)
        add_item(mk(OP_LOAD, 5'd1, 18'sh1FFFF));
        add_item(mk(OP_LOAD, 5'd31, 18'sh20000));
        add_item(mk(OP_LOAD, 5'd0, 18'sh15555));
        add_item(mk(OP_TICK, 5'd0, 18'sh0));
        drain();
        // strong loop, folding on, short period below 2.0
        cfg_write(pslv_pkg::CFG_DELAY_PERIOD, 3);
        cfg_write(pslv_pkg::CFG_LOOP_GAIN, 65536);
        cfg_write(pslv_pkg::CFG_FOLD_THRESHOLD, 20000);
        cfg_write(pslv_pkg::CFG_FOLD_GAIN, 262143);
        cfg_write(pslv_pkg::CFG_DAMPING, 131071);
        cfg_write(pslv_pkg::CFG_DISPERSION, 18'h20000);
        cfg_write(pslv_pkg::CFG_DC_POLE, 131071);
        cfg_write(pslv_pkg::CFG_OUTPUT_GAIN, 262143);
        for (int i = 0; i < 24; i++)
            add_item(mk(i[0] ? OP_LOAD : OP_TICK, 5'(i + 1),
                        i[1] ? 18'sh1FFFF : 18'sh20000));
        drain();

        // random phases through several settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            random_idle = (ph != 2);
            cfg_write(pslv_pkg::CFG_DELAY_PERIOD, ph == 1 ? 22'h3FFFFF :
                      (ph == 3 ? 0 : $urandom_range(512, 24 * 256)));
            cfg_write(pslv_pkg::CFG_FOLD_THRESHOLD, ph == 4 ? 0 : $urandom_range(0, 262143));
            cfg_write(pslv_pkg::CFG_FOLD_GAIN, $urandom_range(0, 262143));
            cfg_write(pslv_pkg::CFG_DAMPING, ph == 5 ? 0 : $urandom_range(0, 65536));
            cfg_write(pslv_pkg::CFG_LOOP_GAIN, ph == 5 ? 0 : $urandom_range(50000, 65536));
            cfg_write(pslv_pkg::CFG_DISPERSION, ph == 4 ? 18'h1FFFF : 18'($urandom));
            cfg_write(pslv_pkg::CFG_DC_POLE, ph == 3 ? 0 : $urandom_range(60000, 65536));
            cfg_write(pslv_pkg::CFG_OUTPUT_GAIN, ph == 3 ? 0 : $urandom_range(0, 262143));
            add_random(N_RANDOM / 6);
            drain();
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
